@@ sv/tea_block_cipher_unit_defines.svh @@
// Assertion macros for the TEA cipher unit
`ifndef TEA_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define TEA_BLOCK_CIPHER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define TBC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TBC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TBC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TBC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ sv/tbc_pkg.sv @@
`timescale 1ns / 1ps
package tbc_pkg;

  localparam logic [31:0] DELTA      = 32'h9e3779b9;
  localparam logic [31:0] DEC_SUM_32 = 32'hc6ef3720;
  localparam logic [31:0] DEC_SUM_16 = 32'he3779b90;

  localparam int unsigned MAX_ROUNDS = 32;
  localparam int unsigned ROUNDS_W   = $clog2(MAX_ROUNDS + 1);

  localparam logic [ROUNDS_W-1:0] ROUNDS_32 = ROUNDS_W'(32);
  localparam logic [ROUNDS_W-1:0] ROUNDS_16 = ROUNDS_W'(16);

  // "1234567890abcdek" as little-endian words
  localparam logic [31:0] KEY_A_RESET = 32'h34333231;
  localparam logic [31:0] KEY_B_RESET = 32'h38373635;
  localparam logic [31:0] KEY_C_RESET = 32'h62613039;
  localparam logic [31:0] KEY_D_RESET = 32'h6b656463;

  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_A,
    REG_KEY_B,
    REG_KEY_C,
    REG_KEY_D,
    REG_ROUND_SEL
  } reg_idx_t;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] left_in;
    logic [31:0] right_in;
  } blk_beat_t;

  typedef struct packed {
    logic [31:0] left_out;
    logic [31:0] right_out;
  } res_beat_t;

  typedef struct packed {
    logic [31:0] key_word_a;
    logic [31:0] key_word_b;
    logic [31:0] key_word_c;
    logic [31:0] key_word_d;
    logic        round_select;
  } key_t;

  typedef struct packed {
    logic                dec;
    logic [31:0]         left;
    logic [31:0]         right;
    logic [31:0]         sum;
    logic [ROUNDS_W-1:0] rounds_left;
  } lane_t;

  function automatic logic [31:0] mix(input logic [31:0] w, input logic [31:0] s,
                                      input logic [31:0] kl, input logic [31:0] kh);
    mix = ((w << 4) + kl) ^ (w + s) ^ ((w >> 5) + kh);
  endfunction

endpackage

@@ sv/tbc_cfg.sv @@
`timescale 1ns / 1ps
module tbc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [tbc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [31:0]                         cfg_data,
  output tbc_pkg::key_t                       key
);

  always_ff @(posedge clk) begin
    if (rst) begin
      key.key_word_a   <= tbc_pkg::KEY_A_RESET;
      key.key_word_b   <= tbc_pkg::KEY_B_RESET;
      key.key_word_c   <= tbc_pkg::KEY_C_RESET;
      key.key_word_d   <= tbc_pkg::KEY_D_RESET;
      key.round_select <= 1'b0;
    end else if (cfg_valid) begin
      case (tbc_pkg::reg_idx_t'(cfg_index))
        tbc_pkg::REG_KEY_A:     key.key_word_a   <= cfg_data;
        tbc_pkg::REG_KEY_B:     key.key_word_b   <= cfg_data;
        tbc_pkg::REG_KEY_C:     key.key_word_c   <= cfg_data;
        tbc_pkg::REG_KEY_D:     key.key_word_d   <= cfg_data;
        tbc_pkg::REG_ROUND_SEL: key.round_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/tbc_round.sv @@
`timescale 1ns / 1ps
`include "tea_block_cipher_unit_defines.svh"
module tbc_round (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  tbc_pkg::key_t  key,
  input  logic           in_valid,
  input  tbc_pkg::lane_t in_lane,
  output logic           out_valid,
  output tbc_pkg::lane_t out_lane
);

  logic                         a_valid;
  tbc_pkg::lane_t               a_lane;
  tbc_pkg::lane_t               a_lane_next;
  tbc_pkg::lane_t               out_lane_next;
  logic [tbc_pkg::ROUNDS_W-1:0] a_count_next;
  logic                         idle_in;
  logic                         step_a;

  assign a_count_next = a_lane.rounds_left - tbc_pkg::ROUNDS_W'(1);
  assign idle_in      = en && in_valid && in_lane.rounds_left == '0;
  assign step_a       = en && a_valid && a_lane.rounds_left != '0;

  // first half: encrypt updates left, decrypt updates right
  always_comb begin
    a_lane_next = in_lane;
    if (in_lane.rounds_left != '0) begin
      if (in_lane.dec) begin
        a_lane_next.right = in_lane.right - tbc_pkg::mix(in_lane.left, in_lane.sum,
                                                         key.key_word_c, key.key_word_d);
      end else begin
        a_lane_next.left = in_lane.left + tbc_pkg::mix(in_lane.right, in_lane.sum,
                                                       key.key_word_a, key.key_word_b);
      end
    end
  end

  // second half: the other word, then step the sum
  always_comb begin
    out_lane_next = a_lane;
    if (a_lane.rounds_left != '0) begin
      out_lane_next.rounds_left = a_count_next;
      if (a_lane.dec) begin
        out_lane_next.left = a_lane.left - tbc_pkg::mix(a_lane.right, a_lane.sum,
                                                        key.key_word_a, key.key_word_b);
        out_lane_next.sum  = a_lane.sum - tbc_pkg::DELTA;
      end else begin
        out_lane_next.right = a_lane.right + tbc_pkg::mix(a_lane.left, a_lane.sum,
                                                          key.key_word_c, key.key_word_d);
        out_lane_next.sum   = a_lane.sum + tbc_pkg::DELTA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_lane   <= a_lane_next;
      out_lane <= out_lane_next;
    end
  end

  `TBC_ASSERT_NXT(a_idle_pass, clk, rst, idle_in, a_lane == $past(in_lane))
  `TBC_ASSERT_NXT(b_count_step, clk, rst, step_a, out_lane.rounds_left == $past(a_count_next))

endmodule

@@ sv/tea_block_cipher_unit.sv @@
`timescale 1ns / 1ps
// channel | direction | handshake             | payload
// blk     | in        | blk_valid / blk_stall | cmd, left_in, right_in
// res     | out       | res_valid / res_stall | left_out, right_out
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One block per cycle while res is not stalled; each block passes 32 unrolled rounds of
// two half-round register stages each. 16-round blocks pass idle through the last
// 16 rounds. Reset clears all stage valid bits and loads the default key.
// A stalled result freezes the whole pipeline, and blk_stall rises with it.
`include "tea_block_cipher_unit_defines.svh"
module tea_block_cipher_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            blk_valid,
  output logic                            blk_stall,
  input  tbc_pkg::blk_beat_t              blk,
  output logic                            res_valid,
  input  logic                            res_stall,
  output tbc_pkg::res_beat_t              res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);

  tbc_pkg::key_t                     key;
  tbc_pkg::lane_t                    lane [0:tbc_pkg::MAX_ROUNDS];
  tbc_pkg::lane_t                    lane_in;
  logic [tbc_pkg::MAX_ROUNDS:0]      valid;
  logic                              en;

  assign cfg_ready = 1'b1;

  tbc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  assign en        = !(res_valid && res_stall);
  assign blk_stall = !en;

  always_comb begin
    lane_in.dec         = blk.cmd;
    lane_in.left        = blk.left_in;
    lane_in.right       = blk.right_in;
    lane_in.rounds_left = key.round_select ? tbc_pkg::ROUNDS_32 : tbc_pkg::ROUNDS_16;
    if (tbc_pkg::cmd_t'(blk.cmd) == tbc_pkg::CMD_DECRYPT) begin
      lane_in.sum = key.round_select ? tbc_pkg::DEC_SUM_32 : tbc_pkg::DEC_SUM_16;
    end else begin
      lane_in.sum = tbc_pkg::DELTA;
    end
  end

  assign valid[0] = blk_valid;
  assign lane[0]  = lane_in;

  for (genvar r = 0; r < tbc_pkg::MAX_ROUNDS; r++) begin : g_round
    tbc_round u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .key       (key),
      .in_valid  (valid[r]),
      .in_lane   (lane[r]),
      .out_valid (valid[r+1]),
      .out_lane  (lane[r+1])
    );
  end

  assign res_valid     = valid[tbc_pkg::MAX_ROUNDS];
  assign res.left_out  = lane[tbc_pkg::MAX_ROUNDS].left;
  assign res.right_out = lane[tbc_pkg::MAX_ROUNDS].right;

  `TBC_ASSERT_IMP(res_rounds_done, clk, rst, res_valid, lane[tbc_pkg::MAX_ROUNDS].rounds_left == '0)
  `TBC_ASSERT_NXT(res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res))

endmodule
